[hw/rtl/rigid_body_world_inertia_top_macros.svh]
// Assertion macros for the world inertia block
`ifndef RIGID_BODY_WORLD_INERTIA_TOP_MACROS_SVH
`define RIGID_BODY_WORLD_INERTIA_TOP_MACROS_SVH

// same-cycle implication
`define RBWI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBWI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rbwi_pkg.sv]
// Package: widths, payload types and constants of the world inertia block
`timescale 1ns / 1ps
`default_nettype none
package rbwi_pkg;
    localparam int FRAC       = 14;
    localparam int RND_HALF   = 1 << (FRAC - 1);
    localparam int N_W        = 33;
    localparam int NUM_W      = 35;
    localparam int MAG_W      = 33;
    localparam int REM_W      = 49;
    localparam int Q_W        = 15;
    localparam int DIV_STAGES = Q_W;
    localparam int ROT_W      = 16;
    localparam int TEN_W      = 32;
    localparam int P1_W       = 48;
    localparam int S1_W       = 50;
    localparam int T_W        = 36;
    localparam int P2_W       = 52;
    localparam int S2_W       = 54;
    localparam int MAT_N      = 9;

    typedef logic signed [ROT_W-1:0] t_rot;
    typedef logic signed [TEN_W-1:0] t_ten;

    localparam t_rot ONE_Q14 = t_rot'(1 << FRAC);
    localparam t_ten TEN_MAX = {1'b0, {(TEN_W-1){1'b1}}};
    localparam t_ten TEN_MIN = {1'b1, {(TEN_W-1){1'b0}}};

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_MID   = 2'd1;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    typedef struct packed {
        t_rot quat_r;
        t_rot quat_i;
        t_rot quat_j;
        t_rot quat_k;
        t_ten body_xx;
        t_ten body_yy;
        t_ten body_zz;
        t_ten body_xy;
        t_ten body_xz;
        t_ten body_yz;
    } t_in_item;

    typedef struct packed {
        logic [1:0] row_index;
        t_rot       rot_col0;
        t_rot       rot_col1;
        t_rot       rot_col2;
        t_ten       world_col0;
        t_ten       world_col1;
        t_ten       world_col2;
        logic       last_row;
    } t_out_item;

    typedef struct packed {
        t_ten xx;
        t_ten yy;
        t_ten zz;
        t_ten xy;
        t_ten xz;
        t_ten yz;
    } t_tensor;

    typedef struct packed {
        logic [MAT_N-1:0]            neg;
        logic                        zero;
        logic [N_W-1:0]              n;
        logic [MAT_N-1:0][REM_W-1:0] rem;
        logic [MAT_N-1:0][Q_W-1:0]   q;
        t_tensor                     ten;
    } t_div_ctx;

    typedef struct packed {
        t_rot [MAT_N-1:0] rot;
        t_tensor          ten;
    } t_rot_ctx;

    typedef struct packed {
        t_rot [MAT_N-1:0] rot;
        t_ten [MAT_N-1:0] world;
    } t_res_ctx;
endpackage
`default_nettype wire

[hw/rtl/rbwi_stream_if.sv]
// Valid/ready stream interface carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none
interface rbwi_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rbwi_quat_front.sv]
// Quaternion front end: component products, squared norm, division operands
`timescale 1ns / 1ps
`default_nettype none
module rbwi_quat_front import rbwi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_div_ctx o_ctx
);
    logic                    r_v_a;
    logic signed [31:0]      r_rr, r_ii, r_jj, r_kk, r_ij, r_rk, r_ik, r_rj, r_jk, r_ri;
    t_tensor                 r_ten_a;
    logic                    r_v_b;
    t_div_ctx                r_ctx;

    logic signed [NUM_W-1:0] w_n;
    logic signed [NUM_W-1:0] w_num [MAT_N];
    logic        [NUM_W-1:0] w_abs [MAT_N];
    t_div_ctx                n_ctx;

    // stage A: ten 16x16 products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
        end else if (i_adv) begin
            r_v_a <= i_valid;
        end
        if (i_adv) begin
            r_rr    <= i_item.quat_r * i_item.quat_r;
            r_ii    <= i_item.quat_i * i_item.quat_i;
            r_jj    <= i_item.quat_j * i_item.quat_j;
            r_kk    <= i_item.quat_k * i_item.quat_k;
            r_ij    <= i_item.quat_i * i_item.quat_j;
            r_rk    <= i_item.quat_r * i_item.quat_k;
            r_ik    <= i_item.quat_i * i_item.quat_k;
            r_rj    <= i_item.quat_r * i_item.quat_j;
            r_jk    <= i_item.quat_j * i_item.quat_k;
            r_ri    <= i_item.quat_r * i_item.quat_i;
            r_ten_a <= '{xx: i_item.body_xx, yy: i_item.body_yy, zz: i_item.body_zz,
                         xy: i_item.body_xy, xz: i_item.body_xz, yz: i_item.body_yz};
        end
    end

    // stage B: numerators and dividends 2*|num|*2^14 + n
    always_comb begin
        w_n = NUM_W'(r_rr) + NUM_W'(r_ii) + NUM_W'(r_jj) + NUM_W'(r_kk);
        w_num[0] = w_n - ((NUM_W'(r_jj) + NUM_W'(r_kk)) <<< 1);
        w_num[1] = (NUM_W'(r_ij) - NUM_W'(r_rk)) <<< 1;
        w_num[2] = (NUM_W'(r_ik) + NUM_W'(r_rj)) <<< 1;
        w_num[3] = (NUM_W'(r_ij) + NUM_W'(r_rk)) <<< 1;
        w_num[4] = w_n - ((NUM_W'(r_ii) + NUM_W'(r_kk)) <<< 1);
        w_num[5] = (NUM_W'(r_jk) - NUM_W'(r_ri)) <<< 1;
        w_num[6] = (NUM_W'(r_ik) - NUM_W'(r_rj)) <<< 1;
        w_num[7] = (NUM_W'(r_jk) + NUM_W'(r_ri)) <<< 1;
        w_num[8] = w_n - ((NUM_W'(r_ii) + NUM_W'(r_jj)) <<< 1);
        n_ctx      = '0;
        n_ctx.n    = w_n[N_W-1:0];
        n_ctx.zero = (w_n == '0);
        n_ctx.ten  = r_ten_a;
        for (int e = 0; e < MAT_N; e++) begin
            n_ctx.neg[e] = w_num[e][NUM_W-1];
            w_abs[e]     = w_num[e][NUM_W-1] ? -w_num[e] : w_num[e];
            n_ctx.rem[e] = (REM_W'(w_abs[e][MAG_W-1:0]) << (FRAC + 1)) + REM_W'(w_n[N_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_b <= 1'b0;
        end else if (i_adv) begin
            r_v_b <= r_v_a;
        end
        if (i_adv) begin
            r_ctx <= n_ctx;
        end
    end

    assign o_valid = r_v_b;
    assign o_ctx   = r_ctx;
endmodule
`default_nettype wire

[hw/rtl/rbwi_rot_div.sv]
// Pipelined restoring divider for the nine rotation entries, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rbwi_rot_div import rbwi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_div_ctx i_ctx,
    output logic     o_valid,
    output t_rot_ctx o_rot
);
    logic     r_v   [DIV_STAGES];
    t_div_ctx r_ctx [DIV_STAGES];
    logic     r_v_f;
    t_rot_ctx r_rot;
    t_rot_ctx n_rot;
    t_div_ctx w_last;
    logic [ROT_W-1:0] w_q16;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic             w_vin;
        t_div_ctx         w_in;
        t_div_ctx         w_out;
        logic [REM_W-1:0] w_dsh;

        if (s == 0) begin : g_head
            assign w_vin = i_valid;
            assign w_in  = i_ctx;
        end else begin : g_body
            assign w_vin = r_v[s-1];
            assign w_in  = r_ctx[s-1];
        end

        // divisor is 2n aligned to this stage's quotient bit
        always_comb begin
            w_dsh = REM_W'({w_in.n, 1'b0}) << (Q_W - 1 - s);
            w_out = w_in;
            for (int e = 0; e < MAT_N; e++) begin
                if (w_in.rem[e] >= w_dsh) begin
                    w_out.rem[e]            = w_in.rem[e] - w_dsh;
                    w_out.q[e][Q_W - 1 - s] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_adv) begin
                r_v[s] <= w_vin;
            end
            if (i_adv) begin
                r_ctx[s] <= w_out;
            end
        end
    end

    // |num| <= n bounds the quotient to 2^14, so it always fits Q2.14
    always_comb begin
        w_last    = r_ctx[DIV_STAGES-1];
        n_rot.ten = w_last.ten;
        w_q16     = '0;
        for (int e = 0; e < MAT_N; e++) begin
            w_q16 = ROT_W'(w_last.q[e]);
            if (w_last.zero) begin
                n_rot.rot[e] = (e == 0 || e == 4 || e == 8) ? ONE_Q14 : t_rot'(0);
            end else begin
                n_rot.rot[e] = w_last.neg[e] ? t_rot'(-w_q16) : t_rot'(w_q16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_f <= 1'b0;
        end else if (i_adv) begin
            r_v_f <= r_v[DIV_STAGES-1];
        end
        if (i_adv) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_v_f;
    assign o_rot   = r_rot;
endmodule
`default_nettype wire

[hw/rtl/rbwi_xform.sv]
// Change of basis W = R * I * R^T in four stages: multiply, sum/round, multiply, sum/round/saturate
`timescale 1ns / 1ps
`default_nettype none
module rbwi_xform import rbwi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_rot_ctx i_rot,
    output logic     o_valid,
    output t_res_ctx o_res
);
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic signed [P1_W-1:0]   r_p1 [MAT_N][3];
    logic signed [T_W-1:0]    r_t  [MAT_N];
    logic signed [P2_W-1:0]   r_p2 [MAT_N][3];
    t_rot [MAT_N-1:0]         r_rot1, r_rot2, r_rot3;
    t_res_ctx                 r_res;

    t_ten                     w_imat [MAT_N];
    logic signed [S1_W-1:0]   w_s1;
    logic signed [T_W-1:0]    w_t  [MAT_N];
    logic signed [S2_W-1:0]   w_s2;
    logic signed [S2_W-1:0]   w_q2;
    t_ten                     w_w  [MAT_N];

    // symmetric tensor, row-major
    always_comb begin
        w_imat[0] = i_rot.ten.xx;
        w_imat[1] = i_rot.ten.xy;
        w_imat[2] = i_rot.ten.xz;
        w_imat[3] = i_rot.ten.xy;
        w_imat[4] = i_rot.ten.yy;
        w_imat[5] = i_rot.ten.yz;
        w_imat[6] = i_rot.ten.xz;
        w_imat[7] = i_rot.ten.yz;
        w_imat[8] = i_rot.ten.zz;
    end

    // rounding ties away from zero: add half, less one when negative, then shift
    always_comb begin
        w_s1 = '0;
        for (int e = 0; e < MAT_N; e++) begin
            w_s1 = S1_W'(r_p1[e][0]) + S1_W'(r_p1[e][1]) + S1_W'(r_p1[e][2]);
            w_s1 = w_s1 + (w_s1[S1_W-1] ? S1_W'(RND_HALF - 1) : S1_W'(RND_HALF));
            w_t[e] = T_W'(w_s1 >>> FRAC);
        end
    end

    always_comb begin
        w_s2 = '0;
        w_q2 = '0;
        for (int e = 0; e < MAT_N; e++) begin
            w_s2 = S2_W'(r_p2[e][0]) + S2_W'(r_p2[e][1]) + S2_W'(r_p2[e][2]);
            w_s2 = w_s2 + (w_s2[S2_W-1] ? S2_W'(RND_HALF - 1) : S2_W'(RND_HALF));
            w_q2 = w_s2 >>> FRAC;
            if (w_q2 > S2_W'(TEN_MAX)) begin
                w_w[e] = TEN_MAX;
            end else if (w_q2 < S2_W'(TEN_MIN)) begin
                w_w[e] = TEN_MIN;
            end else begin
                w_w[e] = TEN_W'(w_q2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_p1[a*3+b][c] <= i_rot.rot[a*3+c] * w_imat[c*3+b];
                        r_p2[a*3+b][c] <= r_t[a*3+c] * r_rot2[b*3+c];
                    end
                end
            end
            for (int e = 0; e < MAT_N; e++) begin
                r_t[e]         <= w_t[e];
                r_res.world[e] <= w_w[e];
            end
            r_rot1    <= i_rot.rot;
            r_rot2    <= r_rot1;
            r_rot3    <= r_rot2;
            r_res.rot <= r_rot3;
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;
endmodule
`default_nettype wire

[hw/rtl/rbwi_row_out.sv]
// Output hold register: sends one finished body as three row beats
`timescale 1ns / 1ps
`default_nettype none
module rbwi_row_out import rbwi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_res_ctx      i_res,
    output logic          o_load_ok,
    rbwi_stream_if.source o_out
);
    logic       r_hv;
    logic [1:0] r_row;
    t_res_ctx   r_hold;
    logic       w_fire;
    logic       w_done;
    logic       w_load;
    logic [3:0] w_base;

    assign w_fire    = o_out.valid && o_out.ready;
    assign w_done    = w_fire && (r_row == ROW_LAST);
    assign o_load_ok = !r_hv || w_done;
    assign w_load    = i_valid && o_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_row <= ROW_FIRST;
        end else if (w_load) begin
            r_hv  <= 1'b1;
            r_row <= ROW_FIRST;
        end else if (w_done) begin
            r_hv  <= 1'b0;
        end else if (w_fire) begin
            r_row <= r_row + 2'd1;
        end
        if (w_load) begin
            r_hold <= i_res;
        end
    end

    always_comb begin
        case (r_row)
            ROW_FIRST: w_base = 4'd0;
            ROW_MID:   w_base = 4'd3;
            default:   w_base = 4'd6;
        endcase
        o_out.valid           = r_hv;
        o_out.data.row_index  = r_row;
        o_out.data.rot_col0   = r_hold.rot[w_base];
        o_out.data.rot_col1   = r_hold.rot[w_base + 4'd1];
        o_out.data.rot_col2   = r_hold.rot[w_base + 4'd2];
        o_out.data.world_col0 = r_hold.world[w_base];
        o_out.data.world_col1 = r_hold.world[w_base + 4'd1];
        o_out.data.world_col2 = r_hold.world[w_base + 4'd2];
        o_out.data.last_row   = (r_row == ROW_LAST);
    end
endmodule
`default_nettype wire

[hw/rtl/rigid_body_world_inertia_top.sv]
// Top level: quaternion to rotation matrix and world-space inverse inertia tensor
// The first row beat is presented from the hold register once the body has passed the front end,
// divider and transform registers; rows follow on consecutive cycles while the sink is ready.
// Bodies leave no faster than the three row beats out of the hold register allow;
// the 22-stage pipeline (15 divider stages) takes a new body every cycle when not stalled.
// Reset: synchronous, active low; clears all valid bits and the row counter.
`timescale 1ns / 1ps
`default_nettype none
`include "rigid_body_world_inertia_top_macros.svh"
module rigid_body_world_inertia_top import rbwi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rbwi_stream_if.sink   i_in,
    rbwi_stream_if.source o_out
);
    logic     w_adv;
    logic     w_front_v;
    t_div_ctx w_front_ctx;
    logic     w_div_v;
    t_rot_ctx w_div_rot;
    logic     w_xf_v;
    t_res_ctx w_xf_res;
    logic     w_load_ok;

    // whole pipeline moves unless a finished body is stuck in front of the hold register
    assign w_adv      = !w_xf_v || w_load_ok;
    assign i_in.ready = w_adv;

    rbwi_quat_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_valid (w_front_v),
        .o_ctx   (w_front_ctx)
    );

    rbwi_rot_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_front_v),
        .i_ctx   (w_front_ctx),
        .o_valid (w_div_v),
        .o_rot   (w_div_rot)
    );

    rbwi_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_div_v),
        .i_rot   (w_div_rot),
        .o_valid (w_xf_v),
        .o_res   (w_xf_res)
    );

    rbwi_row_out u_row_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_xf_v),
        .i_res     (w_xf_res),
        .o_load_ok (w_load_ok),
        .o_out     (o_out)
    );

    `RBWI_ASSERT_IMP(a_first_row, i_clk, i_rst_n, $rose(o_out.valid), o_out.data.row_index == ROW_FIRST, "beat run does not start at row 0")
    `RBWI_ASSERT_NXT(a_row_step, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.data.last_row, o_out.valid && (o_out.data.row_index == $past(o_out.data.row_index) + 2'd1), "row beats not consecutive")
    `RBWI_ASSERT_IMP(a_drop_after_last, i_clk, i_rst_n, $fell(o_out.valid), $past(o_out.ready && o_out.data.last_row), "output dropped before last row beat")
endmodule
`default_nettype wire
